/* rtl/srsd_pkg.sv */
// Package with types, codes and the record type table of the sensor record stream decoder.
package srsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 24;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int LEFT_W  = 4;

    // Output queue depth; an accepted byte can push up to two results.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PUSH  = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_RECORD    = 2'd0;
    localparam logic [STAT_W-1:0] ST_END_CLEAN = 2'd1;
    localparam logic [STAT_W-1:0] ST_END_TRUNC = 2'd2;
    localparam logic [STAT_W-1:0] ST_END_STOP  = 2'd3;

    // Record kind codes.
    localparam logic [KIND_W-1:0] KIND_BATTERY  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TEMP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HUMIDITY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PRESSURE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CURRENT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POWER    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ANALOG   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_GPS      = 3'd7;

    // Type bytes as they appear in the payload.
    localparam logic [BYTE_W-1:0] TYPE_BATTERY  = 8'd116;
    localparam logic [BYTE_W-1:0] TYPE_TEMP     = 8'd103;
    localparam logic [BYTE_W-1:0] TYPE_HUMIDITY = 8'd104;
    localparam logic [BYTE_W-1:0] TYPE_PRESSURE = 8'd115;
    localparam logic [BYTE_W-1:0] TYPE_CURRENT  = 8'd117;
    localparam logic [BYTE_W-1:0] TYPE_POWER    = 8'd128;
    localparam logic [BYTE_W-1:0] TYPE_ANALOG   = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_GPS      = 8'd136;

    // Data lengths in bytes.
    localparam logic [LEFT_W-1:0] LEN_WORD = 4'd2;
    localparam logic [LEFT_W-1:0] LEN_BYTE = 4'd1;
    localparam logic [LEFT_W-1:0] LEN_GPS  = 4'd9;
    // GPS byte positions by bytes still due: latitude above 6, longitude above 3.
    localparam logic [LEFT_W-1:0] GPS_LAT_ABOVE = 4'd6;
    localparam logic [LEFT_W-1:0] GPS_LON_ABOVE = 4'd3;

    typedef enum logic [3:0] {
        PH_CHANNEL = 4'b0001,
        PH_TYPE    = 4'b0010,
        PH_DATA    = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic [KIND_W-1:0]         kind;
        logic [BYTE_W-1:0]         channel;
        logic signed [VALUE_W-1:0] value_a;
        logic signed [VALUE_W-1:0] value_b;
        logic                      last;
    } t_result;

    // Results produced by one accepted byte: a record, an end marker, or both.
    typedef struct packed {
        logic    rec_v;
        logic    fin_v;
        t_result rec;
        t_result fin;
    } t_push;

    typedef struct packed {
        logic              known;
        logic [KIND_W-1:0] kind;
        logic [LEFT_W-1:0] len;
    } t_class;

    function automatic t_class classify(input logic [BYTE_W-1:0] type_byte);
        t_class c;
        c.known = 1'b1;
        c.kind  = KIND_BATTERY;
        c.len   = LEN_WORD;
        unique case (type_byte)
            TYPE_BATTERY:  c.kind = KIND_BATTERY;
            TYPE_TEMP:     c.kind = KIND_TEMP;
            TYPE_HUMIDITY: begin
                c.kind = KIND_HUMIDITY;
                c.len  = LEN_BYTE;
            end
            TYPE_PRESSURE: c.kind = KIND_PRESSURE;
            TYPE_CURRENT:  c.kind = KIND_CURRENT;
            TYPE_POWER:    c.kind = KIND_POWER;
            TYPE_ANALOG:   c.kind = KIND_ANALOG;
            TYPE_GPS: begin
                c.kind = KIND_GPS;
                c.len  = LEN_GPS;
            end
            default:       c.known = 1'b0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/srsd_if.sv */
// Handshake interfaces for the payload byte channel and the result channel.
interface srsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srsd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [2:0]         kind;
    logic [7:0]         channel;
    logic signed [23:0] value_a;
    logic signed [23:0] value_b;
    logic               last;

    modport source (output valid, output status, output kind, output channel,
                    output value_a, output value_b, output last, input ready);
    modport sink   (input valid, input status, input kind, input channel,
                    input value_a, input value_b, input last, output ready);
endinterface

/* rtl/srsd_parse.sv */
// Record parser: holds the decoding state and forms the results of each accepted byte.
module srsd_parse
    import srsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output t_push             o_push
);

    t_phase              r_phase,   n_phase;
    logic [LEFT_W-1:0]   r_left,    n_left;
    logic [KIND_W-1:0]   r_kind,    n_kind;
    logic [BYTE_W-1:0]   r_chan,    n_chan;
    logic [VALUE_W-1:0]  r_first,   n_first;
    logic [VALUE_W-1:0]  r_second,  n_second;

    t_class              cls;
    logic [LEFT_W-1:0]   left_dec;
    logic [VALUE_W-1:0]  rec_a;
    logic [VALUE_W-1:0]  rec_b;
    t_push               push;

    assign cls      = classify(i_data_byte);
    assign left_dec = r_left - LEN_BYTE;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_kind   = r_kind;
        n_chan   = r_chan;
        n_first  = r_first;
        n_second = r_second;
        rec_a    = '0;
        rec_b    = '0;
        push     = '0;

        unique case (r_phase)
            PH_CHANNEL: begin
                n_chan  = i_data_byte;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (cls.known) begin
                    n_kind   = cls.kind;
                    n_left   = cls.len;
                    n_first  = '0;
                    n_second = '0;
                    n_phase  = PH_DATA;
                end else begin
                    n_phase  = PH_STOPPED;
                end
            end
            PH_DATA: begin
                // GPS altitude bytes fall through both branches and are dropped.
                if (r_kind == KIND_GPS) begin
                    if (r_left > GPS_LAT_ABOVE) begin
                        n_first = {r_first[VALUE_W-BYTE_W-1:0], i_data_byte};
                    end else if (r_left > GPS_LON_ABOVE) begin
                        n_second = {r_second[VALUE_W-BYTE_W-1:0], i_data_byte};
                    end
                end else begin
                    n_first = {r_first[VALUE_W-BYTE_W-1:0], i_data_byte};
                end
                n_left = left_dec;
                if (left_dec == '0) begin
                    rec_a = n_first;
                    if (r_kind == KIND_TEMP || r_kind == KIND_ANALOG) begin
                        rec_a = {{(VALUE_W-16){n_first[15]}}, n_first[15:0]};
                    end else if (r_kind == KIND_GPS) begin
                        rec_b = n_second;
                    end
                    push.rec_v         = 1'b1;
                    push.rec.status    = ST_RECORD;
                    push.rec.kind      = r_kind;
                    push.rec.channel   = r_chan;
                    push.rec.value_a   = rec_a;
                    push.rec.value_b   = rec_b;
                    push.rec.last      = 1'b0;
                    n_phase            = PH_CHANNEL;
                end
            end
            PH_STOPPED: begin
            end
            default: begin
            end
        endcase

        if (i_last_byte) begin
            push.fin_v = 1'b1;
            priority if (n_phase == PH_STOPPED) begin
                push.fin.status = ST_END_STOP;
            end else if (n_phase == PH_CHANNEL) begin
                push.fin.status = ST_END_CLEAN;
            end else begin
                push.fin.status = ST_END_TRUNC;
            end
            push.fin.last = 1'b1;
            n_phase  = PH_CHANNEL;
            n_left   = '0;
            n_kind   = '0;
            n_chan   = '0;
            n_first  = '0;
            n_second = '0;
        end

        if (!i_accept) begin
            push.rec_v = 1'b0;
            push.fin_v = 1'b0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CHANNEL;
            r_left   <= '0;
            r_kind   <= '0;
            r_chan   <= '0;
            r_first  <= '0;
            r_second <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_kind   <= n_kind;
            r_chan   <= n_chan;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

/* rtl/srsd_outq.sv */
// Result queue: takes up to two results per cycle and hands out one per cycle while i_pop is high.
module srsd_outq
    import srsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr, n_wr;
    logic [OUTQ_PTR_W-1:0]  r_rd, n_rd;
    logic [OUTQ_CNT_W-1:0]  r_count, n_count;

    logic                   pop;
    logic                   wr0_v;
    logic                   wr1_v;
    t_result                wr0_d;
    logic [OUTQ_CNT_W-1:0]  push_n;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;
    // Room for a record plus an end marker, regardless of this cycle's pop.
    assign o_room  = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - OUTQ_PUSH));

    // A lone end marker goes into the first free slot.
    assign wr0_v  = i_push.rec_v || i_push.fin_v;
    assign wr0_d  = i_push.rec_v ? i_push.rec : i_push.fin;
    assign wr1_v  = i_push.rec_v && i_push.fin_v;
    assign push_n = OUTQ_CNT_W'(wr0_v) + OUTQ_CNT_W'(wr1_v);

    always_comb begin
        n_wr    = r_wr + OUTQ_PTR_W'(push_n);
        n_rd    = r_rd + OUTQ_PTR_W'(pop);
        n_count = r_count + push_n - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (wr0_v) begin
            r_mem[r_wr] <= wr0_d;
        end
        if (wr1_v) begin
            r_mem[r_wr + OUTQ_PTR_W'(1)] <= i_push.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/sensor_record_stream_decoder.sv */
// Top level of the sensor record stream decoder: byte channel in, result channel out.
//
// Usage: payload bytes enter on i_in, one per transfer, with last_byte set on the
// final byte of each payload. Each byte is parsed into channel, type and data
// bytes; every finished record leaves on o_out as one transfer with status
// "record", its kind, channel and raw big-endian value (sign-extended for
// temperature and analog, latitude and longitude for GPS).
// The final byte of a payload also produces an end transfer (last set) that
// reports a clean end, a truncated record, or a stop after an unknown type.
// With the result queue empty, a result is offered on o_out in the cycle after
// the byte that completes it is transferred in.
// Throughput: one byte per cycle while the queue has room. A final byte that also
// completes a record yields two results, and the single-result-per-cycle output then sets the pace.
// A four-entry result queue sits between the parser and o_out; i_in.ready is
// held low when fewer than two slots are free, so a stalled receiver backs
// up into the byte channel without losing or repeating results.
// Reset (synchronous, active low) returns the parser to "expecting channel
// byte" and empties the result queue.
module sensor_record_stream_decoder
    import srsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    srsd_in_if.sink     i_in,
    srsd_out_if.source  o_out
);

    logic    accept;
    logic    room;
    t_push   push;
    t_result head;
    logic    head_v;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    // Parser: state update and result forming for each accepted byte.
    srsd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_push      (push)
    );

    // Result queue decouples the parser from receiver stalls.
    srsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (head_v),
        .o_head  (head)
    );

    assign o_out.valid   = head_v;
    assign o_out.status  = head.status;
    assign o_out.kind    = head.kind;
    assign o_out.channel = head.channel;
    assign o_out.value_a = head.value_a;
    assign o_out.value_b = head.value_b;
    assign o_out.last    = head.last;

endmodule
